// File: rtl/mkcd_pkg.sv
// Shared types and constants of the multi-key click detector.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none
package mkcd_pkg;

	localparam int unsigned KEY_W   = 3;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned OUT_CLICK_W = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PRESS_LEVEL      = 3'd0,
		CFG_DEBOUNCE_TICKS   = 3'd1,
		CFG_LONG_PRESS_TICKS = 3'd2,
		CFG_REPEAT_TICKS     = 3'd3,
		CFG_CLICK_GAP_TICKS  = 3'd4
	} cfg_index_t;

	localparam logic        RST_PRESS_LEVEL      = 1'b0;
	localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd3;
	localparam logic [15:0] RST_LONG_PRESS_TICKS = 16'd200;
	localparam logic [15:0] RST_REPEAT_TICKS     = 16'd20;
	localparam logic [15:0] RST_CLICK_GAP_TICKS  = 16'd60;

	typedef enum logic [2:0] {
		PH_RELEASED      = 3'd0,
		PH_PRESSED       = 3'd1,
		PH_WAIT_AGAIN    = 3'd2,
		PH_PRESSED_AGAIN = 3'd3,
		PH_WAIT_RELEASE  = 3'd4
	} phase_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_LONG    = 3'd3,
		EV_REPEAT  = 3'd4,
		EV_SINGLE  = 3'd5,
		EV_DOUBLE  = 3'd6,
		EV_MULTI   = 3'd7
	} event_t;

	// Per-key state without the click count, whose width is a parameter.
	typedef struct packed {
		logic        stable;
		logic [7:0]  bounce;
		phase_t      phase;
		logic [15:0] ticks;
	} key_state_t;

endpackage
`default_nettype wire

// File: rtl/mkcd_if.sv
// Valid/ready channels of the click detector: poll ticks in, events out.
// Depends on mkcd_pkg for field widths and the event code type.
`default_nettype none
interface mkcd_tick_if import mkcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_index;
	logic             raw_level;

	modport source (output valid, key_index, raw_level, input ready);
	modport sink   (input valid, key_index, raw_level, output ready);
endinterface

interface mkcd_event_if import mkcd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KEY_W-1:0]       event_key;
	event_t                 event_code;
	logic [OUT_CLICK_W-1:0] clicks;

	modport source (output valid, event_key, event_code, clicks, input ready);
	modport sink   (input valid, event_key, event_code, clicks, output ready);
endinterface
`default_nettype wire

// File: rtl/multi_key_click_detector_unit.sv
// Multi-key click detector: debounce, press/release, long press, repeat and
// click counting for NUM_KEYS keys, with per-key state held in memory.
// Depends on mkcd_pkg and the channel interfaces in mkcd_if.sv.
//
// Usage: each request on the tick channel is one poll sample of one key
// (key_index, raw_level). Every request yields exactly one request on the
// event channel carrying the key, an event code (possibly none) and the
// key's click count after the sample. A key index at or above NUM_KEYS
// yields event none with a click count of zero and leaves all state alone.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// while no request is in flight; indexes past the last register are ignored.
// An accepted sample goes through the compute stage and then the output register;
// a new sample is taken every cycle while the event receiver keeps up. The rate is
// set by the state memory's single read-modify-write per sample; a write forward
// register covers a sample of the same key arriving right behind the previous one.
// Reset clears the valid flags and the per-key valid bits, so every key reads
// as released with zero counts; no clearing pass is needed. When the event
// receiver stalls, one result waits in the output register and one more in
// the compute stage, after which tick ready drops until the output drains.
`default_nettype none
module multi_key_click_detector_unit import mkcd_pkg::*; #(
	parameter int unsigned NUM_KEYS    = 8,
	parameter int unsigned CLICK_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	mkcd_tick_if.sink                   tick,
	mkcd_event_if.source                evt,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [CLICK_WIDTH-1:0] CLICK_MAX = {CLICK_WIDTH{1'b1}};

	// Configuration registers.
	logic        press_level_q;
	logic [7:0]  debounce_q;
	logic [15:0] long_press_q;
	logic [15:0] repeat_q;
	logic [15:0] click_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_level_q <= RST_PRESS_LEVEL;
			debounce_q    <= RST_DEBOUNCE_TICKS;
			long_press_q  <= RST_LONG_PRESS_TICKS;
			repeat_q      <= RST_REPEAT_TICKS;
			click_gap_q   <= RST_CLICK_GAP_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESS_LEVEL:      press_level_q <= cfg_data[0];
				CFG_DEBOUNCE_TICKS:   debounce_q    <= cfg_data[7:0];
				CFG_LONG_PRESS_TICKS: long_press_q  <= cfg_data;
				CFG_REPEAT_TICKS:     repeat_q      <= cfg_data;
				CFG_CLICK_GAP_TICKS:  click_gap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// State memories: one for the key state, one for the click count.
	key_state_t             st_mem  [NUM_KEYS];
	logic [CLICK_WIDTH-1:0] clk_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0]    init_q;

	// Handshake and stage control.
	logic valid_s1;
	logic evt_valid_q;
	logic advance;
	logic accept;
	logic s1_fire;
	logic wr_en;

	assign advance   = !evt_valid_q || evt.ready;
	assign tick.ready = !valid_s1 || advance;
	assign accept    = tick.valid && tick.ready;
	assign s1_fire   = valid_s1 && advance;

	// Address of the incoming key; indexes beyond the key count are ignored.
	logic [8:0]        key_wide;
	logic              in_range;
	logic [KEY_AW-1:0] rd_addr;

	assign key_wide = {{(9 - KEY_W){1'b0}}, tick.key_index};
	assign in_range = key_wide < 9'(NUM_KEYS);
	assign rd_addr  = key_wide[KEY_AW-1:0];

	logic [KEY_W-1:0]       key_s1;
	logic                   raw_s1;
	logic                   in_range_s1;
	logic [KEY_AW-1:0]      addr_s1;
	key_state_t             rd_st_s1;
	logic [CLICK_WIDTH-1:0] rd_clk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1      <= tick.key_index;
			raw_s1      <= tick.raw_level;
			in_range_s1 <= in_range;
			addr_s1     <= rd_addr;
			rd_st_s1    <= st_mem[rd_addr];
			rd_clk_s1   <= clk_mem[rd_addr];
		end
	end

	// The last write is kept so that a read issued at the same edge still
	// sees it; it always holds the newest value of its key.
	logic                   fwd_valid_q;
	logic [KEY_AW-1:0]      fwd_addr_q;
	key_state_t             fwd_st_q;
	logic [CLICK_WIDTH-1:0] fwd_clk_q;

	key_state_t             cur_st;
	logic [CLICK_WIDTH-1:0] cur_clk;
	key_state_t             nxt_st;
	logic [CLICK_WIDTH-1:0] nxt_clk;
	event_t                 ev;
	logic                   now_pressed;
	logic [7:0]             bounce_inc;
	logic [15:0]            tick_inc;
	logic [31:0]            clk_ext;

	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			cur_st  = fwd_st_q;
			cur_clk = fwd_clk_q;
		end else if (init_q[addr_s1]) begin
			cur_st  = rd_st_s1;
			cur_clk = rd_clk_s1;
		end else begin
			cur_st  = '0;
			cur_clk = '0;
		end

		nxt_st  = cur_st;
		nxt_clk = cur_clk;
		ev      = EV_NONE;

		now_pressed = (raw_s1 == press_level_q);
		bounce_inc  = cur_st.bounce + 8'd1;
		if (now_pressed != cur_st.stable) begin
			if (bounce_inc >= debounce_q) begin
				nxt_st.stable = now_pressed;
				nxt_st.bounce = 8'd0;
			end else begin
				nxt_st.bounce = bounce_inc;
			end
		end else begin
			nxt_st.bounce = 8'd0;
		end

		tick_inc = (cur_st.ticks == 16'hFFFF) ? cur_st.ticks : cur_st.ticks + 16'd1;

		case (cur_st.phase)
			PH_RELEASED: begin
				if (nxt_st.stable) begin
					ev           = EV_PRESS;
					nxt_st.ticks = 16'd0;
					nxt_clk      = CLICK_WIDTH'(1);
					nxt_st.phase = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!nxt_st.stable) begin
					ev           = EV_RELEASE;
					nxt_st.ticks = 16'd0;
					nxt_st.phase = PH_WAIT_AGAIN;
				end else begin
					nxt_st.ticks = tick_inc;
					if (tick_inc > long_press_q) begin
						ev           = EV_LONG;
						nxt_st.phase = PH_WAIT_RELEASE;
					end
				end
			end
			PH_WAIT_AGAIN: begin
				if (nxt_st.stable) begin
					ev = EV_PRESS;
					if (cur_clk != CLICK_MAX) begin
						nxt_clk = cur_clk + CLICK_WIDTH'(1);
					end
					nxt_st.ticks = 16'd0;
					nxt_st.phase = PH_PRESSED_AGAIN;
				end else begin
					nxt_st.ticks = tick_inc;
					if (tick_inc > click_gap_q) begin
						if (cur_clk == CLICK_WIDTH'(1)) begin
							ev = EV_SINGLE;
						end else if (cur_clk == CLICK_WIDTH'(2)) begin
							ev = EV_DOUBLE;
						end else begin
							ev = EV_MULTI;
						end
						nxt_st.phase = PH_RELEASED;
					end
				end
			end
			PH_PRESSED_AGAIN: begin
				if (!nxt_st.stable) begin
					ev           = EV_RELEASE;
					nxt_st.ticks = 16'd0;
					nxt_st.phase = PH_WAIT_AGAIN;
				end
			end
			PH_WAIT_RELEASE: begin
				if (nxt_st.stable) begin
					nxt_st.ticks = tick_inc;
					if (tick_inc > repeat_q) begin
						nxt_st.ticks = 16'd0;
						ev           = EV_REPEAT;
					end
				end else begin
					ev           = EV_RELEASE;
					nxt_st.ticks = 16'd0;
					nxt_clk      = '0;
					nxt_st.phase = PH_RELEASED;
				end
			end
			default: begin
				// A corrupt phase falls back to released with cleared counts.
				nxt_st.ticks = 16'd0;
				nxt_clk      = '0;
				nxt_st.phase = PH_RELEASED;
			end
		endcase

		clk_ext = 32'(nxt_clk);
	end

	assign wr_en = s1_fire && in_range_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			st_mem[addr_s1]  <= nxt_st;
			clk_mem[addr_s1] <= nxt_clk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			init_q[addr_s1] <= 1'b1;
			fwd_valid_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_st_q   <= nxt_st;
			fwd_clk_q  <= nxt_clk;
		end
	end

	// Output register.
	logic [KEY_W-1:0]       evt_key_q;
	event_t                 evt_code_q;
	logic [OUT_CLICK_W-1:0] evt_clicks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (s1_fire) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			evt_key_q    <= key_s1;
			evt_code_q   <= in_range_s1 ? ev : EV_NONE;
			evt_clicks_q <= in_range_s1 ? clk_ext[OUT_CLICK_W-1:0] : '0;
		end
	end

	assign evt.valid      = evt_valid_q;
	assign evt.event_key  = evt_key_q;
	assign evt.event_code = evt_code_q;
	assign evt.clicks     = evt_clicks_q;

	// An empty compute stage must always take a new request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> tick.ready)
		else $error("tick ready low with an empty compute stage");

	// State is written back only for an in-range key leaving the compute stage.
	a_write_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (valid_s1 && advance && in_range_s1))
		else $error("state write without a departing in-range request");

	// A key written in a pressed phase always carries at least one click.
	a_pressed_has_clicks: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (nxt_st.phase == PH_PRESSED || nxt_st.phase == PH_PRESSED_AGAIN))
		|-> nxt_clk != '0)
		else $error("pressed phase written with zero clicks");

	// The result offered belongs to the request that left the compute stage.
	a_event_key_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> (evt.valid && evt.event_key == $past(key_s1)))
		else $error("event key does not match the departed request");

	// An out-of-range key never reports an event.
	a_out_of_range_none: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !in_range_s1) |=> (evt.event_code == EV_NONE && evt.clicks == '0))
		else $error("event reported for an out-of-range key");

endmodule
`default_nettype wire
